[sv/sdtb_pkg.sv]
// Shared types, scale tables and lookup function for the diatonic triad builder.
`timescale 1ns / 1ps

package sdtb_pkg;

    localparam int NOTE_W      = 7;
    localparam int SEL_W       = 4;
    localparam int OFF_W       = 5;
    localparam int COUNT_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_COUNT = 13;
    localparam int SCALE_MAX   = 12;

    localparam logic [NOTE_W-1:0] ROOT_RESET = 7'd60;
    localparam logic [SEL_W-1:0]  SEL_RESET  = 4'd0;
    localparam logic [SEL_W-1:0]  SEL_CHROM  = 4'd0;
    localparam logic [3:0]        OCTAVE     = 4'd12;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 2'd1;

    localparam logic [3:0] SCALE_LEN [SCALE_COUNT] = '{
        4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd8, 4'd7, 4'd7, 4'd5, 4'd6
    };

    // Semitone steps within one octave; unused slots are zero.
    localparam logic [3:0] SCALE_TAB [SCALE_COUNT][SCALE_MAX] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd6, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] third_off;
        logic [OFF_W-1:0] fifth_off;
    } t_lookup;

    typedef struct packed {
        logic [NOTE_W-1:0]  base;
        logic [NOTE_W-1:0]  third;
        logic [NOTE_W-1:0]  fifth;
        logic [COUNT_W-1:0] count;
        logic               in_scale;
    } t_chord;

    // Semitone distance from degree k to degree k+n, wrapping at most one octave.
    function automatic logic [OFF_W-1:0] degree_off(input logic [3:0] sel,
                                                    input logic [3:0] k,
                                                    input logic [2:0] n);
        logic [4:0] j;
        logic [4:0] len;
        logic [4:0] step;
        j   = 5'(k) + 5'(n);
        len = 5'(SCALE_LEN[sel]);
        if (j >= len) begin
            step = 5'(SCALE_TAB[sel][4'(j - len)]) + 5'(OCTAVE);
        end else begin
            step = 5'(SCALE_TAB[sel][4'(j)]);
        end
        return step - 5'(SCALE_TAB[sel][k]);
    endfunction

    function automatic t_lookup scale_lookup(input logic [SEL_W-1:0] sel_raw,
                                             input logic [3:0]       sem);
        t_lookup    res;
        logic [3:0] sel;
        logic [3:0] kk;
        res = '0;
        sel = (sel_raw < 4'(SCALE_COUNT)) ? sel_raw : SEL_CHROM;
        for (int k = 0; k < SCALE_MAX; k++) begin
            kk = 4'(k);
            if (!res.hit && kk < SCALE_LEN[sel] && SCALE_TAB[sel][kk] == sem) begin
                res.hit       = 1'b1;
                res.third_off = degree_off(sel, kk, 3'd2);
                res.fifth_off = degree_off(sel, kk, 3'd4);
            end
        end
        return res;
    endfunction

endpackage

[sv/scale_diatonic_triad_builder_core.sv]
// Diatonic triad builder: top level with config registers and two-stage pipeline.
// The played note is captured in an input register, the scale lookup and chord
// adds run in one combinational pass, and the chord lands in a result register,
// when that stage has room, and is offered from there. One request is
// accepted every cycle while the result side keeps taking results; a stalled
// result holds the result register, one more request can still be captured
// behind it, and then the input stalls too. The user writes root_note (index 0,
// reset 60) and scale_select (index 1, reset 0; 13..15 act as chromatic) through
// the plain write port only while no request is in flight; this is not enforced.
`timescale 1ns / 1ps

module scale_diatonic_triad_builder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sdtb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdtb_pkg::NOTE_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sdtb_pkg::NOTE_W-1:0]     i_played_note,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sdtb_pkg::NOTE_W-1:0]     o_chord_base,
    output logic [sdtb_pkg::NOTE_W-1:0]     o_chord_third,
    output logic [sdtb_pkg::NOTE_W-1:0]     o_chord_fifth,
    output logic [sdtb_pkg::COUNT_W-1:0]    o_note_count,
    output logic                            o_in_scale
);
    import sdtb_pkg::*;

    logic [NOTE_W-1:0] r_root;
    logic [SEL_W-1:0]  r_sel;
    logic              r_in_vld;
    logic [NOTE_W-1:0] r_note;
    logic              r_out_vld;
    t_chord            r_chord;
    t_chord            chord;
    logic              out_load;
    logic              in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= ROOT_RESET;
            r_sel  <= SEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROOT_NOTE:    r_root <= i_cfg_data;
                REG_SCALE_SELECT: r_sel  <= i_cfg_data[SEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // advance the result stage when it is empty or being drained
    assign out_load   = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || out_load;
    assign in_load    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_load) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_note <= i_played_note;
        end
        if (out_load && r_in_vld) begin
            r_chord <= chord;
        end
    end

    sdtb_harmonize u_harmonize (
        .i_note  (r_note),
        .i_root  (r_root),
        .i_sel   (r_sel),
        .o_chord (chord)
    );

    assign o_out_valid   = r_out_vld;
    assign o_chord_base  = r_chord.base;
    assign o_chord_third = r_chord.third;
    assign o_chord_fifth = r_chord.fifth;
    assign o_note_count  = r_chord.count;
    assign o_in_scale    = r_chord.in_scale;

    a_out_scale_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_scale |-> o_note_count == 2'd1
            && o_chord_third == '0 && o_chord_fifth == '0)
        else $error("note outside scale produced chord notes");

    a_fifth_needs_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_note_count == 2'd3 |-> o_in_scale)
        else $error("full triad without scale hit");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_note_count != 2'd0)
        else $error("note count of zero");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && out_load |=> r_out_vld)
        else $error("captured request not moved to result stage");

endmodule

[sv/sdtb_harmonize.sv]
// Combinational chord builder: scale membership and third/fifth of one note.
`timescale 1ns / 1ps

module sdtb_harmonize (
    input  logic [sdtb_pkg::NOTE_W-1:0] i_note,
    input  logic [sdtb_pkg::NOTE_W-1:0] i_root,
    input  logic [sdtb_pkg::SEL_W-1:0]  i_sel,
    output sdtb_pkg::t_chord            o_chord
);
    import sdtb_pkg::*;

    logic [NOTE_W:0]   diff;
    logic [NOTE_W-1:0] note_dist;
    logic [12:0]       prod;
    logic [3:0]        oct;
    logic [3:0]        sem;
    t_lookup           lk;
    logic [NOTE_W:0]   third_sum;
    logic [NOTE_W:0]   fifth_sum;
    logic              hit;
    logic              third_ok;
    logic              fifth_ok;

    always_comb begin
        diff      = {1'b0, i_note} - {1'b0, i_root};
        note_dist = diff[NOTE_W-1:0];
        // d / 12 as (d * 43) >> 9, exact for d below 128
        prod      = 13'(note_dist) * 13'd43;
        oct       = prod[12:9];
        sem       = 4'(note_dist - 7'(oct) * 7'(OCTAVE));
        lk        = scale_lookup(i_sel, sem);
        hit       = lk.hit && !diff[NOTE_W];
        third_sum = {1'b0, i_note} + 8'(lk.third_off);
        fifth_sum = {1'b0, i_note} + 8'(lk.fifth_off);
        third_ok  = hit && !third_sum[NOTE_W];
        fifth_ok  = hit && !fifth_sum[NOTE_W];

        o_chord.base     = i_note;
        o_chord.third    = third_ok ? third_sum[NOTE_W-1:0] : '0;
        o_chord.fifth    = fifth_ok ? fifth_sum[NOTE_W-1:0] : '0;
        o_chord.count    = 2'd1 + 2'(third_ok) + 2'(fifth_ok);
        o_chord.in_scale = hit;
    end

endmodule

[test/tb_scale_diatonic_triad_builder_core.sv]
// Self-checking testbench for the diatonic triad builder: directed table plus random phases.
`timescale 1ns / 1ps

module tb_scale_diatonic_triad_builder_core;

    import sdtb_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 7;
    localparam int DRAIN       = 4;
    localparam int WAIT_LIMIT  = 5000;
    localparam int PHASES      = 25;
    localparam int PER_PHASE   = 50;
    localparam int NOTE_MAX    = 127;
    localparam int SEMIS       = 12;
    localparam int SCALE_ROWS  = 13;
    localparam int OCT_SPAN    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef enum logic [SEL_W-1:0] {
        SC_CHROMATIC, SC_MAJOR, SC_MINOR, SC_HARM_MINOR, SC_PHRYGIAN, SC_LYDIAN,
        SC_MIXOLYDIAN, SC_WHOLE_TONE, SC_DIMINISHED, SC_LYD_DOMINANT, SC_HUNGARIAN,
        SC_PENT_MINOR, SC_BLUES, SC_SPARE_13, SC_SPARE_14, SC_SPARE_15
    } t_scale;

    // Interval sets per scale, in semitones above the root of each octave.
    localparam int SCALE_SIZE [SCALE_ROWS] = '{12, 7, 7, 7, 7, 7, 7, 6, 8, 7, 7, 5, 6};
    localparam int SCALE_STEPS [SCALE_ROWS][OCT_SPAN] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11},
        '{0, 2, 4, 5, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 8, 10, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 1, 3, 5, 7, 8, 10, 0, 0, 0, 0, 0},
        '{0, 2, 4, 6, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 2, 4, 5, 7, 9, 10, 0, 0, 0, 0, 0},
        '{0, 2, 4, 6, 8, 10, 0, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 6, 8, 9, 11, 0, 0, 0, 0},
        '{0, 2, 4, 6, 7, 9, 10, 0, 0, 0, 0, 0},
        '{0, 2, 3, 6, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 3, 5, 7, 10, 0, 0, 0, 0, 0, 0, 0},
        '{0, 3, 5, 6, 7, 10, 0, 0, 0, 0, 0, 0}
    };

    typedef enum logic [1:0] {ROW_WRITE, ROW_NOTE, ROW_NOTE_LIT} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [NOTE_W-1:0]      val;
        t_chord                 lit;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [NOTE_W-1:0]      i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [NOTE_W-1:0]      i_played_note = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [NOTE_W-1:0]      o_chord_base;
    logic [NOTE_W-1:0]      o_chord_third;
    logic [NOTE_W-1:0]      o_chord_fifth;
    logic [COUNT_W-1:0]     o_note_count;
    logic                   o_in_scale;

    t_chord                 pending_chords[$];
    t_dir_row               dir_rows[$];
    logic [NOTE_W-1:0]      cur_root = ROOT_RESET;
    logic [SEL_W-1:0]       cur_sel  = SEL_RESET;
    bit                     quiet_phase = 1'b0;
    int                     err_count = 0;
    int                     notes_sent = 0;
    int                     chords_checked = 0;
    int                     scale_hits = 0;
    int                     full_triads = 0;
    int                     settings_used = 1;
    int                     out_hold = 0;

    scale_diatonic_triad_builder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_played_note (i_played_note),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_chord_base  (o_chord_base),
        .o_chord_third (o_chord_third),
        .o_chord_fifth (o_chord_fifth),
        .o_note_count  (o_note_count),
        .o_in_scale    (o_in_scale)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d chords still outstanding", pending_chords.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Build the ascending ladder of scale notes from the root and index into it.
    function automatic t_chord harmonize_note(input logic [NOTE_W-1:0] note,
                                              input logic [NOTE_W-1:0] root,
                                              input logic [SEL_W-1:0]  sel_raw);
        int     ladder[$];
        int     row;
        int     pos;
        t_chord c;
        row = (int'(sel_raw) >= SCALE_ROWS) ? int'(SC_CHROMATIC) : int'(sel_raw);
        for (int o = 0; o < OCT_SPAN; o++) begin
            for (int d = 0; d < SCALE_SIZE[row]; d++) begin
                ladder = {ladder, int'(root) + SCALE_STEPS[row][d] + SEMIS * o};
            end
        end
        pos = -1;
        foreach (ladder[i]) begin
            if (pos < 0 && ladder[i] == int'(note)) pos = i;
        end
        c = '0;
        c.base  = note;
        c.count = 2'd1;
        if (pos >= 0) begin
            c.in_scale = 1'b1;
            if (ladder[pos + 2] <= NOTE_MAX) begin
                c.third = NOTE_W'(ladder[pos + 2]);
                c.count = c.count + 2'd1;
            end
            if (ladder[pos + 4] <= NOTE_MAX) begin
                c.fifth = NOTE_W'(ladder[pos + 4]);
                c.count = c.count + 2'd1;
            end
        end
        return c;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Favor notes that land on the scale so the chord paths get exercised.
    function automatic logic [NOTE_W-1:0] pick_note();
        int row;
        int n;
        row = (int'(cur_sel) >= SCALE_ROWS) ? int'(SC_CHROMATIC) : int'(cur_sel);
        if ($urandom_range(0, 9) < 6) begin
            n = int'(cur_root) + SCALE_STEPS[row][$urandom_range(0, SCALE_SIZE[row] - 1)]
                + SEMIS * $urandom_range(0, 10);
            if (n <= NOTE_MAX) return NOTE_W'(n);
        end
        return NOTE_W'($urandom_range(0, NOTE_MAX));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40) begin
            $display("MISMATCH @%0t %s: got %0d, want %0d", $realtime, what, got, want);
        end
        err_count++;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [NOTE_W-1:0] val);
        t_dir_row row;
        row      = '{ROW_WRITE, idx, val, t_chord'('0)};
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_note(input logic [NOTE_W-1:0] n);
        t_dir_row row;
        row      = '{ROW_NOTE, '0, n, t_chord'('0)};
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_lit(input logic [NOTE_W-1:0] n, input logic [NOTE_W-1:0] third,
                           input logic [NOTE_W-1:0] fifth, input logic [COUNT_W-1:0] cnt,
                           input logic hit);
        t_dir_row row;
        row      = '{ROW_NOTE_LIT, '0, n, t_chord'({n, third, fifth, cnt, hit})};
        dir_rows = {dir_rows, row};
    endtask

    // Write lowers the enable again before returning, so back-to-back writes never run together.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [NOTE_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_ROOT_NOTE) cur_root = val;
        else if (idx == REG_SCALE_SELECT) cur_sel = val[SEL_W-1:0];
        @(posedge i_clk);
    endtask

    // Hold off new requests until every chord has come back, then let the pipe empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        for (int w = 0; w < WAIT_LIMIT && pending_chords.size() > 0; w++) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic play_note(input logic [NOTE_W-1:0] n, input bit use_lit, input t_chord lit);
        t_chord exp_chord;
        i_in_valid    <= 1'b1;
        i_played_note <= n;
        do @(posedge i_clk); while (!o_in_ready);
        exp_chord      = use_lit ? lit : harmonize_note(n, cur_root, cur_sel);
        pending_chords = {pending_chords, exp_chord};
        notes_sent++;
    endtask

    task automatic sender_idle();
        int gap;
        gap = (!quiet_phase && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side: check each accepted chord, then pick the next ready level.
    always @(posedge i_clk) begin
        t_chord want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chords.size() == 0) begin
                report_mismatch("unexpected chord, base", int'(o_chord_base), -1);
            end else begin
                want = pending_chords.pop_front();
                if (o_chord_base !== want.base)
                    report_mismatch("chord_base", int'(o_chord_base), int'(want.base));
                if (o_chord_third !== want.third)
                    report_mismatch("chord_third", int'(o_chord_third), int'(want.third));
                if (o_chord_fifth !== want.fifth)
                    report_mismatch("chord_fifth", int'(o_chord_fifth), int'(want.fifth));
                if (o_note_count !== want.count)
                    report_mismatch("note_count", int'(o_note_count), int'(want.count));
                if (o_in_scale !== want.in_scale)
                    report_mismatch("in_scale", int'(o_in_scale), int'(want.in_scale));
                chords_checked++;
                if (want.in_scale) scale_hits++;
                if (want.count == 2'd3) full_triads++;
            end
        end
        if (quiet_phase) begin
            i_out_ready <= 1'b1;
        end else if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold--;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) out_hold = pick_gap();
        end
    end

    initial begin
        logic [NOTE_W-1:0] root_pick;
        logic [NOTE_W-1:0] sel_pick;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: root 60, chromatic.
        add_lit(7'd60, 7'd62, 7'd64, 2'd3, 1'b1);
        add_lit(7'd59, 7'd0, 7'd0, 2'd1, 1'b0);
        add_lit(7'd0, 7'd0, 7'd0, 2'd1, 1'b0);
        add_lit(7'd127, 7'd0, 7'd0, 2'd1, 1'b1);
        add_lit(7'd126, 7'd0, 7'd0, 2'd1, 1'b1);
        add_lit(7'd125, 7'd127, 7'd0, 2'd2, 1'b1);
        add_write(REG_ROOT_NOTE, 7'd0);
        add_write(REG_SCALE_SELECT, 7'(SC_MAJOR));
        add_lit(7'd0, 7'd4, 7'd7, 2'd3, 1'b1);
        add_lit(7'd1, 7'd0, 7'd0, 2'd1, 1'b0);
        add_lit(7'd127, 7'd0, 7'd0, 2'd1, 1'b1);
        add_lit(7'd11, 7'd14, 7'd17, 2'd3, 1'b1);
        // Upper data bits must be dropped; selector 15 falls back to chromatic.
        add_write(REG_SCALE_SELECT, {3'b111, SC_SPARE_15});
        add_lit(7'd1, 7'd3, 7'd5, 2'd3, 1'b1);
        add_write(REG_UNUSED_2, 7'h55);
        add_write(REG_UNUSED_3, 7'h2A);
        add_lit(7'd1, 7'd3, 7'd5, 2'd3, 1'b1);
        add_write(REG_ROOT_NOTE, 7'd127);
        add_write(REG_SCALE_SELECT, 7'(SC_BLUES));
        add_lit(7'd127, 7'd0, 7'd0, 2'd1, 1'b1);
        add_lit(7'd126, 7'd0, 7'd0, 2'd1, 1'b0);
        add_write(REG_ROOT_NOTE, 7'd0);
        for (int s = SC_MINOR; s <= SC_PENT_MINOR; s++) begin
            add_write(REG_SCALE_SELECT, 7'(s));
            add_note(7'(s * 9));
        end

        foreach (dir_rows[r]) begin
            case (dir_rows[r].kind)
                ROW_WRITE: begin
                    settle();
                    cfg_write(dir_rows[r].idx, dir_rows[r].val);
                    settings_used++;
                end
                ROW_NOTE: begin
                    play_note(dir_rows[r].val, 1'b0, t_chord'('0));
                    sender_idle();
                end
                default: begin
                    play_note(dir_rows[r].val, 1'b1, dir_rows[r].lit);
                    sender_idle();
                end
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            quiet_phase = (ph % 5 == 2);
            case (ph)
                0: begin
                    root_pick = 7'd0;
                    sel_pick  = 7'(SC_CHROMATIC);
                end
                1: begin
                    root_pick = 7'd127;
                    sel_pick  = {3'b101, SC_SPARE_15};
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1:    root_pick = 7'd0;
                        2:       root_pick = 7'd127;
                        default: root_pick = NOTE_W'($urandom_range(0, NOTE_MAX));
                    endcase
                    sel_pick = {3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))};
                end
            endcase
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_ROOT_NOTE, root_pick);
                cfg_write(REG_SCALE_SELECT, sel_pick);
            end else begin
                cfg_write(REG_SCALE_SELECT, sel_pick);
                cfg_write(REG_ROOT_NOTE, root_pick);
            end
            if ($urandom_range(0, 3) == 0) begin
                cfg_write($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          NOTE_W'($urandom));
            end
            settings_used++;
            for (int k = 0; k < PER_PHASE; k++) begin
                // Drain completely once in a while before the next request.
                if (ph % 6 == 4 && k == PER_PHASE / 2) settle();
                play_note(pick_note(), 1'b0, t_chord'('0));
                sender_idle();
            end
        end

        settle();
        repeat (DRAIN) @(posedge i_clk);
        if (pending_chords.size() != 0) begin
            report_mismatch("chords never returned", pending_chords.size(), 0);
        end
        $display("Played %0d notes across %0d register settings, checked %0d chords",
                 notes_sent, settings_used, chords_checked);
        $display("%0d notes were in scale, %0d produced a full triad", scale_hits, full_triads);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/sdtb_pkg.sv
sv/sdtb_harmonize.sv
sv/scale_diatonic_triad_builder_core.sv
test/tb_scale_diatonic_triad_builder_core.sv
